// ===== sv/pcm_sample_player_assert.svh =====
// assertion macros shared by the pcm sample player rtl
// no dependencies; included by the files that check their own logic
`ifndef PCM_SAMPLE_PLAYER_ASSERT_SVH
`define PCM_SAMPLE_PLAYER_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property check, disabled while in reset
`define PSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pcm sample player check failed");
// same-cycle implication
`define PSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcm sample player check failed");
// next-cycle implication
`define PSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcm sample player check failed");
`else
`define PSP_ASSERT(lbl, clk, rst_n, prop)
`define PSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/psp_pkg.sv =====
// shared types and constants of the pcm sample player
// no dependencies
package psp_pkg;

    localparam int ADDR_W = 12;
    localparam int LEN_W  = 13;
    localparam int REM_W  = 14;
    localparam int SAMP_W = 8;
    localparam int STEP_W = 16;
    localparam int REQ_W  = 3;

    localparam logic [SAMP_W-1:0] SILENCE = 8'd128;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_PLAY  = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_SPEED = 3'd4,
        REQ_NEXT  = 3'd5
    } t_req;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [SAMP_W-1:0] sample_in;
        logic              repeat_flag;
        logic [STEP_W-1:0] speed_step;
    } t_item;

    // per-request outcome from the sequencer core
    typedef struct packed {
        logic tick_play;
        logic playing;
    } t_core_res;

endpackage

// ===== sv/psp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/psp_core.sv =====
// playback state and phase accumulator of the pcm sample player
// depends on psp_pkg and pcm_sample_player_assert.svh
`include "pcm_sample_player_assert.svh"

module psp_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  psp_pkg::t_item               i_item,
    output psp_pkg::t_core_res           o_res,
    output logic [psp_pkg::ADDR_W-1:0]   o_rd_addr
);

    localparam int STEP_RW = psp_pkg::STEP_W + 1;
    localparam int ACC_W   = STEP_RW + 1;
    localparam logic [STEP_RW-1:0] STEP_ONE = STEP_RW'(1 << FRAC_BITS);

    logic [psp_pkg::ADDR_W-1:0] r_cur, n_cur;
    logic [psp_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [FRAC_BITS-1:0]       r_frac, n_frac;
    logic [STEP_RW-1:0]         r_step, n_step;
    logic [psp_pkg::ADDR_W-1:0] r_nxt_addr, n_nxt_addr;
    logic [psp_pkg::LEN_W-1:0]  r_nxt_len, n_nxt_len;

    logic [ACC_W-1:0]           w_acc;
    logic [ACC_W-1:0]           w_whole;
    logic [psp_pkg::REM_W-1:0]  w_len;
    logic                       w_skip;
    logic                       w_tick_play;

    assign w_acc   = ACC_W'(r_frac) + ACC_W'(r_step);
    assign w_whole = w_acc >> FRAC_BITS;
    assign w_len   = {1'b0, i_item.length};
    assign w_skip  = (r_rem != '0) && (r_nxt_addr == i_item.address)
                     && (r_nxt_len == i_item.length);

    always_comb begin
        n_cur       = r_cur;
        n_rem       = r_rem;
        n_frac      = r_frac;
        n_step      = r_step;
        n_nxt_addr  = r_nxt_addr;
        n_nxt_len   = r_nxt_len;
        w_tick_play = 1'b0;
        unique case (i_item.req_type)
            psp_pkg::REQ_TICK: begin
                if (r_rem != '0) begin
                    w_tick_play = 1'b1;
                    n_frac      = w_acc[FRAC_BITS-1:0];
                    if (w_whole >= ACC_W'(r_rem)) begin
                        // sound used up: reload queued sound
                        n_rem = {1'b0, r_nxt_len};
                        n_cur = r_nxt_addr;
                    end else begin
                        n_rem = r_rem - w_whole[psp_pkg::REM_W-1:0];
                        n_cur = r_cur + w_whole[psp_pkg::ADDR_W-1:0];
                    end
                end
            end
            psp_pkg::REQ_WRITE: begin
            end
            psp_pkg::REQ_PLAY: begin
                n_nxt_len = '0;
                if (i_item.repeat_flag) begin
                    n_nxt_addr = i_item.address;
                    n_nxt_len  = i_item.length;
                end
                n_step = {1'b0, i_item.speed_step};
                n_frac = '0;
                n_cur  = i_item.address;
                n_rem  = w_len;
            end
            psp_pkg::REQ_STOP: begin
                n_rem = '0;
            end
            psp_pkg::REQ_SPEED: begin
                n_step = {1'b0, i_item.speed_step};
            end
            psp_pkg::REQ_NEXT: begin
                if (!w_skip) begin
                    if (r_rem == '0) begin
                        n_cur = i_item.address;
                        n_rem = w_len;
                    end
                    n_nxt_addr = i_item.address;
                    n_nxt_len  = i_item.length;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_rem      <= '0;
            r_frac     <= '0;
            r_step     <= STEP_ONE;
            r_nxt_addr <= '0;
            r_nxt_len  <= '0;
        end else if (i_en) begin
            r_cur      <= n_cur;
            r_rem      <= n_rem;
            r_frac     <= n_frac;
            r_step     <= n_step;
            r_nxt_addr <= n_nxt_addr;
            r_nxt_len  <= n_nxt_len;
        end
    end

    assign o_res.tick_play = w_tick_play;
    assign o_res.playing   = (n_rem != '0);
    assign o_rd_addr       = r_cur;

    // stop always silences the next item
    `PSP_ASSERT_NXT(a_stop_clears, i_clk, i_rst_n,
        i_en && (i_item.req_type == psp_pkg::REQ_STOP), r_rem == '0)
    // play restarts phase at the requested address
    `PSP_ASSERT_NXT(a_play_loads, i_clk, i_rst_n,
        i_en && (i_item.req_type == psp_pkg::REQ_PLAY),
        (r_frac == '0) && (r_cur == $past(i_item.address)))

endmodule

// ===== sv/pcm_sample_player.sv =====
// top level of the pcm sample player: handshake, request register, sample ram
// depends on psp_pkg, psp_ram, psp_core and pcm_sample_player_assert.svh
`include "pcm_sample_player_assert.svh"

// pcm sample player: one request in, one result out, one request per clock
// sustained while the result channel does not stall. a request is taken into
// an input register; when the result slot is free the core updates the
// playback state (phase accumulator, address, remaining count, queued sound)
// and the sample ram is read at the current address, both at the edge that
// also loads the result register. on a tick that is playing, level is the
// stored sample, otherwise 128; playing tells whether samples remain after
// the request. MEM_DEPTH must be a power of two; a sample address is reduced
// modulo MEM_DEPTH. the sample ram has no reset: reading a location that was
// never written gives an arbitrary level. FRAC_BITS sets the fraction width
// of the speed step (one sample per tick is 1 << FRAC_BITS).
module pcm_sample_player #(
    parameter int FRAC_BITS = 8,
    parameter int MEM_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [psp_pkg::REQ_W-1:0]    i_req_type,
    input  logic [psp_pkg::ADDR_W-1:0]   i_address,
    input  logic [psp_pkg::LEN_W-1:0]    i_length,
    input  logic [psp_pkg::SAMP_W-1:0]   i_sample_in,
    input  logic                         i_repeat_flag,
    input  logic [psp_pkg::STEP_W-1:0]   i_speed_step,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [psp_pkg::SAMP_W-1:0]   o_level,
    output logic                         o_playing
);

    localparam int MEM_AW = $clog2(MEM_DEPTH);

    // input register
    logic               r_in_valid;
    psp_pkg::t_item     r_in;
    // result register; level comes from the ram read register
    logic               r_out_valid;
    logic               r_out_tick;
    logic               r_out_playing;

    logic               w_out_free;
    logic               w_proc;
    logic               w_in_take;
    psp_pkg::t_core_res w_res;
    logic [psp_pkg::ADDR_W-1:0] w_rd_addr;
    logic [31:0]        w_waddr_ext;
    logic [31:0]        w_raddr_ext;
    logic [psp_pkg::SAMP_W-1:0] w_rdata;
    logic               w_we;

    // result slot is free if empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // the request in the input register is processed when its result can land
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.req_type    <= i_req_type;
            r_in.address     <= i_address;
            r_in.length      <= i_length;
            r_in.sample_in   <= i_sample_in;
            r_in.repeat_flag <= i_repeat_flag;
            r_in.speed_step  <= i_speed_step;
        end
    end

    psp_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_proc),
        .i_item    (r_in),
        .o_res     (w_res),
        .o_rd_addr (w_rd_addr)
    );

    // sample addresses fold onto the ram depth
    assign w_waddr_ext = 32'(r_in.address);
    assign w_raddr_ext = 32'(w_rd_addr);
    assign w_we        = w_proc && (r_in.req_type == psp_pkg::REQ_WRITE);

    // read data holds while the result waits, as the read only fires on w_proc
    psp_ram #(
        .WIDTH (psp_pkg::SAMP_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr_ext[MEM_AW-1:0]),
        .i_wdata (r_in.sample_in),
        .i_re    (w_proc),
        .i_raddr (w_raddr_ext[MEM_AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_tick    <= w_res.tick_play;
            r_out_playing <= w_res.playing;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_tick ? w_rdata : psp_pkg::SILENCE;
    assign o_playing   = r_out_playing;

    // every processed request shows up as a result
    `PSP_ASSERT_NXT(a_proc_to_out, i_clk, i_rst_n, w_proc, r_out_valid)
    // a stalled result is never dropped
    `PSP_ASSERT_NXT(a_out_kept, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule
